// ----- rtl/core/hodoscope_peak_intime_tagger_core_assert.svh -----
// Assertion macros used by the hodoscope tagger core RTL.
`ifndef HODOSCOPE_PEAK_INTIME_TAGGER_CORE_ASSERT_SVH
`define HODOSCOPE_PEAK_INTIME_TAGGER_CORE_ASSERT_SVH

// Checked on every rising edge of clk once reset is released.
`define HPIT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, also while reset is held.
`define HPIT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/hpit_pkg.sv -----
// Constants, types and helper functions of the hodoscope tagger.
`default_nettype none

package hpit_pkg;

  // Histogram geometry.
  localparam int NUM_DETECTORS   = 16;
  localparam int NUM_BINS        = 200;
  localparam int BIN_WIDTH_SHIFT = 5;
  localparam int FIRST_DETECTOR  = 25;

  // Field widths.
  localparam int TIME_W = 16;
  localparam int ID_W   = 6;
  localparam int CNT_W  = 16;
  localparam int OP_W   = 2;
  localparam int CFG_W  = 16;
  localparam int REG_W  = 2;

  // Derived sizes.
  localparam int DET_W      = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int HIST_DEPTH = NUM_DETECTORS * NUM_BINS;
  localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int SPAN_W     = BIN_W + BIN_WIDTH_SHIFT;
  localparam int CSUM_W     = ((SPAN_W > TIME_W) ? SPAN_W : TIME_W) + 1;
  localparam int HALF_BIN   = (1 << BIN_WIDTH_SHIFT) / 2;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_PEAK_HALF_WINDOW  = 16'd240;
  localparam logic [CFG_W-1:0] RST_FIXED_WINDOW_LOW  = 16'd7200;
  localparam logic [CFG_W-1:0] RST_FIXED_WINDOW_HIGH = 16'd17600;
  localparam logic [CFG_W-1:0] RST_HISTOGRAM_START   = 16'd12800;

  // Center of bin 0 for the reset value of the histogram start.
  localparam int RST_CENTER_RAW = 12800 + HALF_BIN;
  localparam logic [TIME_W-1:0] RST_CENTER =
    TIME_W'((RST_CENTER_RAW > 65535) ? 65535 : RST_CENTER_RAW);

  // Register indexes.
  localparam logic [REG_W-1:0] REG_PEAK_HALF_WINDOW  = 2'd0;
  localparam logic [REG_W-1:0] REG_FIXED_WINDOW_LOW  = 2'd1;
  localparam logic [REG_W-1:0] REG_FIXED_WINDOW_HIGH = 2'd2;
  localparam logic [REG_W-1:0] REG_HISTOGRAM_START   = 2'd3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_FILL     = 2'd0;
  localparam logic [OP_W-1:0] OP_FINALIZE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd2;

  // Result kinds.
  localparam logic KIND_HIT  = 1'b0;
  localparam logic KIND_PEAK = 1'b1;

  localparam logic [DET_W-1:0] DET_LAST      = DET_W'(NUM_DETECTORS - 1);
  localparam logic [BIN_W-1:0] BIN_LAST      = BIN_W'(NUM_BINS - 1);
  localparam logic [ADDR_W-1:0] HIST_LAST    = ADDR_W'(HIST_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL_RD,
    S_FILL_WR,
    S_CLASSIFY,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  // Center of a histogram bin, saturated to the time range.
  function automatic logic [TIME_W-1:0] bin_center(input logic [TIME_W-1:0] start,
                                                   input logic [BIN_W-1:0]  bin);
    logic [CSUM_W-1:0] sum;
    sum = CSUM_W'(start) + (CSUM_W'(bin) << BIN_WIDTH_SHIFT) + CSUM_W'(HALF_BIN);
    if (sum > CSUM_W'(TIME_MAX)) begin
      return TIME_MAX;
    end
    return sum[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hpit_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hpit_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/hodoscope_peak_intime_tagger_core.sv -----
// A classify result is built from the captured item in S_CLASSIFY and registered once the output is free.
// Fill items pass through transfer, RAM read and write back, and give no result.
// Finalize walks the count RAM one bin a cycle, then drains and emits each detector's peak report.
// Throughput is one item at a time; the count RAM port sets the finalize time.
// Reset (rst, synchronous) starts a clearing pass over all NUM_DETECTORS * NUM_BINS
// entries of the count RAM; no item is taken until it ends, config still is.
`default_nettype none

`include "hodoscope_peak_intime_tagger_core_assert.svh"

module hodoscope_peak_intime_tagger_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Input stream.
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [23:0]                 s_tdata,   // detector_id[5:0], tdc_time[21:6]
  input  wire logic [hpit_pkg::OP_W-1:0]   s_tuser,   // opcode[1:0]
  // Result stream.
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [23:0]                 m_tdata,   // out_detector[5:0], in_time[6],
                                                      // handled[7], peak_center[23:8]
  output logic      [0:0]                  m_tuser,   // result_kind[0]
  output logic                             m_tlast,
  // Configuration writes.
  input  wire logic                        cfg_we,
  input  wire logic [hpit_pkg::REG_W-1:0]  cfg_addr,
  input  wire logic [hpit_pkg::CFG_W-1:0]  cfg_wdata
);

  import hpit_pkg::*;

  state_t state, state_next;

  // Configuration registers.
  logic [CFG_W-1:0] peak_half_window;
  logic [CFG_W-1:0] fixed_window_low;
  logic [CFG_W-1:0] fixed_window_high;
  logic [CFG_W-1:0] histogram_start;

  // Accepted item.
  logic [ID_W-1:0]   item_det;
  logic [TIME_W-1:0] item_time;

  // Sweep and scan counters.
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] scan_addr;
  logic [BIN_W-1:0]  scan_bin;
  logic [DET_W-1:0]  scan_det;
  logic              rd_vld;
  logic [BIN_W-1:0]  rd_bin;
  logic [CNT_W-1:0]  best_cnt;
  logic [BIN_W-1:0]  best_bin;

  logic [TIME_W-1:0] peak_centers [NUM_DETECTORS];

  // Count RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CNT_W-1:0]  ram_rdata;

  // Output control.
  logic              out_free;
  logic              out_load;
  logic              out_kind_next;
  logic [ID_W-1:0]   out_det_next;
  logic              out_in_time_next;
  logic              out_handled_next;
  logic [TIME_W-1:0] out_center_next;
  logic              out_last_next;

  logic              in_xfer;

  // Item decode.
  logic              item_hodo;
  logic              item_below;
  logic [DET_W-1:0]  item_idx;
  logic [TIME_W:0]   fill_diff;
  logic [TIME_W-1:0] fill_bin_full;
  logic              fill_ok;
  logic [ADDR_W-1:0] fill_addr;
  logic [TIME_W-1:0] cls_center;
  logic [TIME_W-1:0] cls_diff;
  logic              cls_in_time;
  logic [TIME_W-1:0] emit_center;
  logic              scan_better;

  hpit_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HIST_DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Detector range and histogram address of the held item.
  always_comb begin
    item_hodo     = (int'(item_det) >= FIRST_DETECTOR) &&
                    (int'(item_det) < FIRST_DETECTOR + NUM_DETECTORS);
    item_below    = int'(item_det) < FIRST_DETECTOR;
    item_idx      = DET_W'(int'(item_det) - FIRST_DETECTOR);
    fill_diff     = {1'b0, item_time} - {1'b0, histogram_start};
    fill_bin_full = fill_diff[TIME_W-1:0] >> BIN_WIDTH_SHIFT;
    fill_ok       = item_hodo && !fill_diff[TIME_W] &&
                    (fill_bin_full < TIME_W'(NUM_BINS));
    fill_addr     = ADDR_W'(int'(item_idx) * NUM_BINS + int'(fill_bin_full[BIN_W-1:0]));
  end

  // In-time test of the held item.
  always_comb begin
    cls_center  = peak_centers[item_idx];
    cls_diff    = (item_time >= cls_center) ? (item_time - cls_center)
                                            : (cls_center - item_time);
    if (item_hodo) begin
      cls_in_time = cls_diff < peak_half_window;
    end else begin
      cls_in_time = (item_time > fixed_window_low) && (item_time < fixed_window_high);
    end
  end

  // Peak search compare and the center of the found bin.
  assign scan_better = (rd_bin == '0) || (ram_rdata > best_cnt);
  assign emit_center = bin_center(histogram_start, best_bin);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == HIST_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            OP_FILL:     state_next = S_FILL_RD;
            OP_FINALIZE: state_next = S_SCAN;
            OP_CLASSIFY: state_next = S_CLASSIFY;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_FILL_RD:  state_next = S_FILL_WR;
      S_FILL_WR:  state_next = S_IDLE;
      S_CLASSIFY: begin
        if (out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (scan_bin == BIN_LAST) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = (scan_det == DET_LAST) ? S_IDLE : S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of each state: RAM control, input ready and result loading.
  always_comb begin
    s_tready         = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = fill_addr;
    ram_wdata        = ram_rdata + CNT_W'(1);
    ram_raddr        = fill_addr;
    out_load         = 1'b0;
    out_kind_next    = KIND_HIT;
    out_det_next     = item_det;
    out_in_time_next = 1'b0;
    out_handled_next = 1'b1;
    out_center_next  = '0;
    out_last_next    = 1'b1;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: s_tready = 1'b1;
      S_FILL_WR: begin
        ram_we = fill_ok && (ram_rdata != CNT_MAX);
      end
      S_CLASSIFY: begin
        out_load         = out_free;
        out_in_time_next = !item_below && cls_in_time;
        out_handled_next = !item_below;
      end
      S_SCAN: ram_raddr = scan_addr;
      S_EMIT: begin
        out_load        = out_free;
        out_kind_next   = KIND_PEAK;
        out_det_next    = ID_W'(FIRST_DETECTOR + int'(scan_det));
        out_center_next = emit_center;
        out_last_next   = (scan_det == DET_LAST);
      end
      default: ;
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      rd_vld   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == S_SCAN);
      if (state == S_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // Item capture and finalize walk.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_det  <= s_tdata[ID_W-1:0];
      item_time <= s_tdata[ID_W +: TIME_W];
      scan_addr <= '0;
      scan_bin  <= '0;
      scan_det  <= '0;
    end else begin
      if (state == S_SCAN) begin
        scan_addr <= scan_addr + ADDR_W'(1);
        scan_bin  <= (scan_bin == BIN_LAST) ? '0 : scan_bin + BIN_W'(1);
      end
      if ((state == S_EMIT) && out_free) scan_det <= scan_det + DET_W'(1);
    end
    rd_bin <= scan_bin;
    if (rd_vld && scan_better) begin
      best_cnt <= ram_rdata;
      best_bin <= rd_bin;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_half_window  <= RST_PEAK_HALF_WINDOW;
      fixed_window_low  <= RST_FIXED_WINDOW_LOW;
      fixed_window_high <= RST_FIXED_WINDOW_HIGH;
      histogram_start   <= RST_HISTOGRAM_START;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PEAK_HALF_WINDOW:  peak_half_window  <= cfg_wdata;
        REG_FIXED_WINDOW_LOW:  fixed_window_low  <= cfg_wdata;
        REG_FIXED_WINDOW_HIGH: fixed_window_high <= cfg_wdata;
        REG_HISTOGRAM_START:   histogram_start   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stored peak centers, updated as each report is sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DETECTORS; i++) begin
        peak_centers[i] <= RST_CENTER;
      end
    end else if ((state == S_EMIT) && out_free) begin
      peak_centers[scan_det] <= emit_center;
    end
  end

  // Output register: takes a new result whenever the previous one has gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata    <= {out_center_next, out_handled_next, out_in_time_next, out_det_next};
      m_tuser[0] <= out_kind_next;
      m_tlast    <= out_last_next;
    end
  end

  // A write back never wraps a full counter.
  `HPIT_ASSERT(a_count_saturates, (state == S_FILL_WR) && ram_we |-> ram_rdata != CNT_MAX, "count RAM write would wrap a full counter")
  // The clearing pass ends only after the last entry was written.
  `HPIT_ASSERT(a_clear_complete, (state == S_IDLE) && ($past(state) == S_CLEAR) |-> $past(clr_addr) == HIST_LAST, "clearing pass ended early")
  // The peak walk never writes the count RAM.
  `HPIT_ASSERT(a_scan_read_only, (state == S_SCAN) || (state == S_DRAIN) |-> !ram_we, "count RAM written during peak walk")
  // The last peak report closes the finalize run and is marked last.
  `HPIT_ASSERT(a_final_report, (state == S_EMIT) && out_free && (scan_det == DET_LAST) |=> (state == S_IDLE) && m_tvalid && m_tlast, "final peak report not marked last")
  // No input transfer while the clearing pass runs, also around reset.
  `HPIT_ASSERT_ALWAYS(a_no_xfer_in_clear, (state == S_CLEAR) |-> !in_xfer, "input transfer during clearing pass")

endmodule

`default_nettype wire
